[rtl/fes2d_pkg.sv]
// shared types and constants of the 2d frame element stiffness block
package fes2d_pkg;

    // wide datapath of the shared multiply and divide units
    localparam int WW = 160;
    // divisor width, holds len^3
    localparam int DW = 104;
    // magnitude width of a saturated coefficient or entry
    localparam int MAG_W = 63;
    localparam int MUL_STEPS = 64;
    localparam int DIV_STEPS = 160;
    localparam int COS_BITS = 30;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [MAG_W-1:0] SAT_MAG = '1;

    // configuration register indexes
    localparam logic [1:0] CFG_MODULUS = 2'd0;
    localparam logic [1:0] CFG_OUTER   = 2'd1;
    localparam logic [1:0] CFG_INNER   = 2'd2;

    // one finished element: magnitudes and signs of the distinct entries
    typedef struct packed {
        logic             err;
        logic             n12;
        logic             nds;
        logic             ndc;
        logic [MAG_W-1:0] m11;
        logic [MAG_W-1:0] m22;
        logic [MAG_W-1:0] m12;
        logic [MAG_W-1:0] mds;
        logic [MAG_W-1:0] mdc;
        logic [MAG_W-1:0] ke;
        logic [MAG_W-1:0] kf;
    } rec_t;

endpackage

[rtl/fes2d_mulu.sv]
// bit-serial shift-add multiplier with optional accumulate
module fes2d_mulu
    import fes2d_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          accum,
    input  logic [WW-1:0] a,
    input  logic [63:0]   b,
    output logic [WW-1:0] prod,
    output logic          done
);

    localparam int CW = $clog2(MUL_STEPS);

    logic [WW-1:0] mcand_reg;
    logic [WW-1:0] acc_reg;
    logic [63:0]   mplier_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one multiplier bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= a;
            mplier_reg <= b;
            if (!accum)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

[rtl/fes2d_divu.sv]
// restoring divider, one quotient bit per cycle, quotient saturated to 63 bits
module fes2d_divu
    import fes2d_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WW-1:0]    n,
    input  logic [DW-1:0]    d,
    output logic [MAG_W-1:0] quo,
    output logic             done
);

    localparam int CW = $clog2(DIV_STEPS);

    logic [WW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [63:0]   q_reg;
    logic          over_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          ge;

    // trial subtract
    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[WW-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = (rem_sh >= {1'b0, den_reg});
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= n;
            den_reg  <= d;
            rem_reg  <= '0;
            q_reg    <= '0;
            over_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_reg << 1;
            rem_reg  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            q_reg    <= {q_reg[62:0], ge};
            over_reg <= over_reg | q_reg[63];
        end
    end

    assign quo  = (over_reg || q_reg[63]) ? SAT_MAG : q_reg[MAG_W-1:0];
    assign done = done_reg;

endmodule

[rtl/fes2d_front.sv]
// front end: takes element coordinates and works out the element coefficients
module fes2d_front
    import fes2d_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [19:0]        elastic_modulus,
    input  logic [24:0]        outer_diameter,
    input  logic [24:0]        inner_diameter,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] x_start,
    input  logic signed [31:0] y_start,
    input  logic signed [31:0] x_end,
    input  logic signed [31:0] y_end,
    output logic               push,
    output rec_t               push_rec,
    input  logic               q_full
);

    localparam int K_A = 32;
    localparam int K_E = 34 + 2 * FRAC_BITS;
    localparam int K_F = 35 + 2 * FRAC_BITS;
    localparam int K_D = 35 + FRAC_BITS;
    localparam int K_B = 34;
    localparam logic [5:0] ROOT_LAST = 6'd33;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_ROOT, S_CM, S_SM, S_TRIG, S_N2, S_N4, S_L2, S_L3,
        S_KA, S_KE, S_KF, S_KD, S_KB, S_M11A, S_M11B, S_M22A, S_M22B, S_M12,
        S_MDS, S_MDC, S_PUSH
    } state_t;

    function automatic logic [WW-1:0] half_up(input logic [WW-1:0] nv,
                                              input logic [WW-1:0] dv, input int k);
        logic [WW-1:0] t;
        t = (nv << 1) + (dv << k);
        return t >> (k + 1);
    endfunction

    function automatic logic [MAG_W-1:0] rnd_sat(input logic [WW-1:0] p, input int sh);
        logic [WW-1:0] t;
        t = (p + (WW'(1) << (sh - 1))) >> sh;
        return (|t[WW-1:MAG_W]) ? SAT_MAG : t[MAG_W-1:0];
    endfunction

    state_t state_reg;
    state_t op_next;
    logic   wait_reg;
    logic   hold_valid_reg;
    logic   err_reg;
    logic [5:0] root_cnt_reg;
    logic   take;

    logic signed [31:0] hx0_reg, hy0_reg, hx1_reg, hy1_reg;
    logic signed [32:0] dx_c, dy_c;
    logic [31:0] ux_reg, uy_reg;
    logic        nx_reg, ny_reg;

    // configuration derived terms
    logic [24:0] din_c;
    logic [49:0] dsqo_reg, dsqi_reg;
    logic [51:0] ep_reg;
    logic [49:0] d2_reg;
    logic [50:0] s2_reg;

    // square root
    logic [67:0] rad_reg;
    logic [37:0] rrem_reg;
    logic [33:0] root_reg;
    logic [37:0] rrem_sh, rtrial, rrem_sub;
    logic        rge;
    logic [33:0] root_next;

    logic [30:0]     cm_reg, sm_reg;
    logic [61:0]     cm2_reg, sm2_reg, cs_reg;
    logic [101:0]    n2_reg;
    logic [WW-1:0]   n4_reg, n43_reg;
    logic [67:0]     len2_reg;
    logic [101:0]    len3_reg;
    logic [MAG_W-1:0] ka_reg, kb_reg, kd_reg, ke_reg, kf_reg;
    logic [MAG_W-1:0] m11_reg, m22_reg, m12_reg, mds_reg, mdc_reg;
    logic [MAG_W-1:0] diff_c;
    logic             kneg_c;

    // shared units
    logic             mul_start, mul_accum, mul_done;
    logic [WW-1:0]    mul_a, mul_prod;
    logic [63:0]      mul_b;
    logic             div_start, div_done;
    logic [WW-1:0]    div_n;
    logic [DW-1:0]    div_d;
    logic [MAG_W-1:0] div_quo;
    logic             unit_done;

    fes2d_mulu u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .accum (mul_accum),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    fes2d_divu u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .d     (div_d),
        .quo   (div_quo),
        .done  (div_done)
    );

    assign in_ready = !hold_valid_reg;
    assign take     = (state_reg == S_IDLE) && hold_valid_reg;

    // input differences
    always_comb
    begin
        dx_c = {hx1_reg[31], hx1_reg} - {hx0_reg[31], hx0_reg};
        dy_c = {hy1_reg[31], hy1_reg} - {hy0_reg[31], hy0_reg};
    end

    // coefficient helpers
    always_comb
    begin
        kneg_c = (ka_reg < kb_reg);
        diff_c = kneg_c ? (kb_reg - ka_reg) : (ka_reg - kb_reg);
        din_c  = (inner_diameter > outer_diameter) ? outer_diameter : inner_diameter;
    end

    // square root step
    always_comb
    begin
        rrem_sh  = {rrem_reg[35:0], rad_reg[67:66]};
        rtrial   = {2'b00, root_reg, 2'b01};
        rrem_sub = rrem_sh - rtrial;
        rge      = (rrem_sh >= rtrial);
        root_next = rge ? {root_reg[32:0], 1'b1} : {root_reg[32:0], 1'b0};
    end

    // unit operands for each step
    always_comb
    begin
        mul_start = 1'b0;
        mul_accum = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        unit_done = 1'b0;
        op_next   = S_IDLE;
        case (state_reg)
            S_SQX:
            begin
                mul_a = WW'(ux_reg); mul_b = 64'(ux_reg);
                mul_start = !wait_reg; unit_done = mul_done; op_next = S_SQY;
            end
            S_SQY:
            begin
                mul_a = WW'(uy_reg); mul_b = 64'(uy_reg); mul_accum = 1'b1;
                mul_start = !wait_reg; unit_done = mul_done; op_next = S_ROOT;
            end
            S_CM:
            begin
                div_n = (WW'(ux_reg) << (COS_BITS + 1)) + WW'(root_reg);
                div_d = DW'({root_reg, 1'b0});
                div_start = !wait_reg; unit_done = div_done; op_next = S_SM;
            end
            S_SM:
            begin
                div_n = (WW'(uy_reg) << (COS_BITS + 1)) + WW'(root_reg);
                div_d = DW'({root_reg, 1'b0});
                div_start = !wait_reg; unit_done = div_done; op_next = S_TRIG;
            end
            S_N2:
            begin
                mul_a = WW'(ep_reg); mul_b = 64'(d2_reg);
                mul_start = !wait_reg; unit_done = mul_done; op_next = S_N4;
            end
            S_N4:
            begin
                mul_a = WW'(n2_reg); mul_b = 64'(s2_reg);
                mul_start = !wait_reg; unit_done = mul_done; op_next = S_L2;
            end
            S_L2:
            begin
                mul_a = WW'(root_reg); mul_b = 64'(root_reg);
                mul_start = !wait_reg; unit_done = mul_done; op_next = S_L3;
            end
            S_L3:
            begin
                mul_a = WW'(len2_reg); mul_b = 64'(root_reg);
                mul_start = !wait_reg; unit_done = mul_done; op_next = S_KA;
            end
            S_KA:
            begin
                div_n = half_up(WW'(n2_reg), WW'(root_reg), K_A);
                div_d = DW'(root_reg);
                div_start = !wait_reg; unit_done = div_done; op_next = S_KE;
            end
            S_KE:
            begin
                div_n = half_up(n4_reg, WW'(root_reg), K_E);
                div_d = DW'(root_reg);
                div_start = !wait_reg; unit_done = div_done; op_next = S_KF;
            end
            S_KF:
            begin
                div_n = half_up(n4_reg, WW'(root_reg), K_F);
                div_d = DW'(root_reg);
                div_start = !wait_reg; unit_done = div_done; op_next = S_KD;
            end
            S_KD:
            begin
                div_n = half_up(n43_reg, WW'(len2_reg), K_D);
                div_d = DW'(len2_reg);
                div_start = !wait_reg; unit_done = div_done; op_next = S_KB;
            end
            S_KB:
            begin
                div_n = half_up(n43_reg, WW'(len3_reg), K_B);
                div_d = DW'(len3_reg);
                div_start = !wait_reg; unit_done = div_done; op_next = S_M11A;
            end
            S_M11A:
            begin
                mul_a = WW'(ka_reg); mul_b = 64'(cm2_reg);
                mul_start = !wait_reg; unit_done = mul_done; op_next = S_M11B;
            end
            S_M11B:
            begin
                mul_a = WW'(kb_reg); mul_b = 64'(sm2_reg); mul_accum = 1'b1;
                mul_start = !wait_reg; unit_done = mul_done; op_next = S_M22A;
            end
            S_M22A:
            begin
                mul_a = WW'(ka_reg); mul_b = 64'(sm2_reg);
                mul_start = !wait_reg; unit_done = mul_done; op_next = S_M22B;
            end
            S_M22B:
            begin
                mul_a = WW'(kb_reg); mul_b = 64'(cm2_reg); mul_accum = 1'b1;
                mul_start = !wait_reg; unit_done = mul_done; op_next = S_M12;
            end
            S_M12:
            begin
                mul_a = WW'(diff_c); mul_b = 64'(cs_reg);
                mul_start = !wait_reg; unit_done = mul_done; op_next = S_MDS;
            end
            S_MDS:
            begin
                mul_a = WW'(kd_reg); mul_b = 64'(sm_reg);
                mul_start = !wait_reg; unit_done = mul_done; op_next = S_MDC;
            end
            S_MDC:
            begin
                mul_a = WW'(kd_reg); mul_b = 64'(cm_reg);
                mul_start = !wait_reg; unit_done = mul_done; op_next = S_PUSH;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wait_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            root_cnt_reg   <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                hold_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        state_reg <= S_SQX;
                    end
                end
                S_ROOT:
                begin
                    root_cnt_reg <= root_cnt_reg + 1'b1;
                    if (root_cnt_reg == ROOT_LAST)
                    begin
                        root_cnt_reg <= '0;
                        state_reg    <= (root_next == '0) ? S_PUSH : S_CM;
                    end
                end
                S_TRIG:
                begin
                    state_reg <= S_N2;
                end
                S_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (unit_done)
                    begin
                        wait_reg  <= 1'b0;
                        state_reg <= op_next;
                    end
                end
            endcase
        end
    end

    // configuration products, settled long before first use
    always_ff @(posedge clk)
    begin
        dsqo_reg <= 50'(outer_diameter) * 50'(outer_diameter);
        dsqi_reg <= 50'(din_c) * 50'(din_c);
        ep_reg   <= 52'(elastic_modulus) * 52'(PI_Q30);
        d2_reg   <= dsqo_reg - dsqi_reg;
        s2_reg   <= 51'(dsqo_reg) + 51'(dsqi_reg);
    end

    // input hold stage
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hx0_reg <= x_start;
            hy0_reg <= y_start;
            hx1_reg <= x_end;
            hy1_reg <= y_end;
        end
    end

    // datapath captures
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    ux_reg <= 32'(dx_c[32] ? -dx_c : dx_c);
                    uy_reg <= 32'(dy_c[32] ? -dy_c : dy_c);
                    nx_reg <= dx_c[32];
                    ny_reg <= dy_c[32];
                    err_reg <= 1'b0;
                end
            end
            S_SQY:
            begin
                if (wait_reg && unit_done)
                begin
                    rad_reg  <= mul_prod[67:0];
                    rrem_reg <= '0;
                    root_reg <= '0;
                end
            end
            S_ROOT:
            begin
                rad_reg  <= rad_reg << 2;
                rrem_reg <= rge ? rrem_sub : rrem_sh;
                root_reg <= root_next;
                if (root_cnt_reg == ROOT_LAST)
                begin
                    err_reg <= (root_next == '0);
                end
            end
            S_TRIG:
            begin
                cm2_reg <= 62'(cm_reg) * 62'(cm_reg);
                sm2_reg <= 62'(sm_reg) * 62'(sm_reg);
                cs_reg  <= 62'(cm_reg) * 62'(sm_reg);
            end
            default:
            begin
                if (wait_reg && unit_done)
                begin
                    case (state_reg)
                        S_CM:   cm_reg   <= div_quo[30:0];
                        S_SM:   sm_reg   <= div_quo[30:0];
                        S_N2:   n2_reg   <= mul_prod[101:0];
                        S_N4:
                        begin
                            n4_reg  <= mul_prod;
                            n43_reg <= mul_prod + (mul_prod << 1);
                        end
                        S_L2:   len2_reg <= mul_prod[67:0];
                        S_L3:   len3_reg <= mul_prod[101:0];
                        S_KA:   ka_reg   <= div_quo;
                        S_KE:   ke_reg   <= div_quo;
                        S_KF:   kf_reg   <= div_quo;
                        S_KD:   kd_reg   <= div_quo;
                        S_KB:   kb_reg   <= div_quo;
                        S_M11B: m11_reg  <= rnd_sat(mul_prod, 2 * COS_BITS);
                        S_M22B: m22_reg  <= rnd_sat(mul_prod, 2 * COS_BITS);
                        S_M12:  m12_reg  <= rnd_sat(mul_prod, 2 * COS_BITS);
                        S_MDS:  mds_reg  <= rnd_sat(mul_prod, COS_BITS);
                        S_MDC:  mdc_reg  <= rnd_sat(mul_prod, COS_BITS);
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase
    end

    // finished element to the queue
    assign push = (state_reg == S_PUSH) && !q_full;

    always_comb
    begin
        push_rec.err = err_reg;
        push_rec.n12 = kneg_c ^ nx_reg ^ ny_reg;
        push_rec.nds = ny_reg;
        push_rec.ndc = nx_reg;
        push_rec.m11 = m11_reg;
        push_rec.m22 = m22_reg;
        push_rec.m12 = m12_reg;
        push_rec.mds = mds_reg;
        push_rec.mdc = mdc_reg;
        push_rec.ke  = ke_reg;
        push_rec.kf  = kf_reg;
    end

endmodule

[rtl/fes2d_queue.sv]
// two-entry queue of finished elements between front and back
module fes2d_queue
    import fes2d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t push_rec,
    output logic full,
    input  logic pop,
    output rec_t head,
    output logic empty
);

    rec_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

[rtl/fes2d_back.sv]
// back end: expands one element into its 36 global entries, row by row (one for zero length)
module fes2d_back
    import fes2d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rec_t        head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  row_index,
    output logic [2:0]  col_index,
    output logic [63:0] entry_value,
    output logic        last_entry,
    output logic        length_error
);

    // signed entry at row r, column c of the rotated matrix
    function automatic logic [63:0] pick(input rec_t rc, input logic [2:0] r,
                                         input logic [2:0] c);
        logic             ib;
        logic             jb;
        logic [2:0]       ar;
        logic [2:0]       bc;
        logic [MAG_W-1:0] mag;
        logic             neg;
        ib = (r >= 3'd3);
        jb = (c >= 3'd3);
        ar = ib ? (r - 3'd3) : r;
        bc = jb ? (c - 3'd3) : c;
        if (ar != 3'd2 && bc != 3'd2)
        begin
            if (ar == 3'd0 && bc == 3'd0)
            begin
                mag = rc.m11; neg = (ib != jb);
            end
            else if (ar == 3'd1 && bc == 3'd1)
            begin
                mag = rc.m22; neg = (ib != jb);
            end
            else
            begin
                mag = rc.m12; neg = (ib != jb) ^ rc.n12;
            end
        end
        else if (ar == 3'd2 && bc == 3'd2)
        begin
            mag = (ib == jb) ? rc.ke : rc.kf; neg = 1'b0;
        end
        else if (bc == 3'd2)
        begin
            if (ar == 3'd0)
            begin
                mag = rc.mds; neg = !rc.nds ^ ib;
            end
            else
            begin
                mag = rc.mdc; neg = rc.ndc ^ ib;
            end
        end
        else
        begin
            if (bc == 3'd0)
            begin
                mag = rc.mds; neg = !rc.nds ^ jb;
            end
            else
            begin
                mag = rc.mdc; neg = rc.ndc ^ jb;
            end
        end
        return neg ? -{1'b0, mag} : {1'b0, mag};
    endfunction

    logic [2:0]  r_reg, c_reg;
    logic        out_valid_reg;
    logic [2:0]  row_reg, col_reg;
    logic [63:0] val_reg;
    logic        last_reg, err_reg;
    logic        load;
    logic        at_end;

    assign load   = !empty && (!out_valid_reg || out_ready);
    assign at_end = (r_reg == 3'd5) && (c_reg == 3'd5);
    assign pop    = load && (head.err || at_end);

    // entry counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg         <= '0;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (!head.err)
                begin
                    if (c_reg == 3'd5)
                    begin
                        c_reg <= '0;
                        r_reg <= at_end ? 3'd0 : r_reg + 3'd1;
                    end
                    else
                    begin
                        c_reg <= c_reg + 3'd1;
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg  <= head.err ? 3'd0 : r_reg;
            col_reg  <= head.err ? 3'd0 : c_reg;
            val_reg  <= head.err ? 64'd0 : pick(head, r_reg, c_reg);
            last_reg <= head.err || at_end;
            err_reg  <= head.err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_index    = row_reg;
    assign col_index    = col_reg;
    assign entry_value  = val_reg;
    assign last_entry   = last_reg;
    assign length_error = err_reg;

endmodule

[rtl/frame_element_stiffness_2d_core.sv]
// top level of the 2d frame element global stiffness block
//
//  channel   direction  handshake                contents
//  s_*       in         s_tvalid / s_tready      element end coordinates
//  m_*       out        m_tvalid / m_tready      stiffness entries, tlast on the last
//  cfg_*     in         cfg_valid / cfg_ready    register index and write data
//
// the front end runs thirteen bit-serial multiplies, seven restoring divides and a
// 34-step square root per element, all on one shared multiply unit and one shared
// divide unit; the back end emits one entry per cycle while an element is queued and
// m_tready is high (36 per element, one for a zero-length element) and overlaps the
// next element's front-end work through a two-entry queue
// reset is asynchronous, active low; control and config registers return to reset values
// either side may stall at any time; the input hold stage takes a new element
// while the front end is still busy
module frame_element_stiffness_2d_core
    import fes2d_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,    // x_start, y_start, x_end, y_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,    // row_index, col_index, entry_value, zero pad
    output logic         m_tlast,    // last_entry
    output logic [0:0]   m_tuser,    // length_error
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [24:0]  cfg_data
);

    logic [19:0] modulus_reg;
    logic [24:0] outer_reg;
    logic [24:0] inner_reg;

    logic        push, q_full, pop, q_empty;
    rec_t        push_rec, head;
    logic [2:0]  row_index, col_index;
    logic [63:0] entry_value;
    logic        last_entry, length_error;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= 20'd205000;
            outer_reg   <= 25'd1664614;
            inner_reg   <= 25'd1245184;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODULUS: modulus_reg <= cfg_data[19:0];
                CFG_OUTER:   outer_reg   <= cfg_data;
                CFG_INNER:   inner_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    fes2d_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .elastic_modulus (modulus_reg),
        .outer_diameter  (outer_reg),
        .inner_diameter  (inner_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .x_start         (s_tdata[31:0]),
        .y_start         (s_tdata[63:32]),
        .x_end           (s_tdata[95:64]),
        .y_end           (s_tdata[127:96]),
        .push            (push),
        .push_rec        (push_rec),
        .q_full          (q_full)
    );

    fes2d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    fes2d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (q_empty),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .row_index    (row_index),
        .col_index    (col_index),
        .entry_value  (entry_value),
        .last_entry   (last_entry),
        .length_error (length_error)
    );

    // output packing
    assign m_tdata    = {2'b00, entry_value, col_index, row_index};
    assign m_tlast    = last_entry;
    assign m_tuser[0] = length_error;

endmodule

[rtl/fes2d_checker.sv]
// port-level checks of the stiffness block, bound to the top level
module fes2d_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [127:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [71:0]  m_tdata,
    input logic         m_tlast,
    input logic [0:0]   m_tuser,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [1:0]   cfg_index,
    input logic [24:0]  cfg_data
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // zero-length element gives one all-zero last request
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 72'd0))
        else $error("length error result malformed");

    // a full matrix ends at row 5, column 5
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && !m_tuser[0] |-> (m_tdata[2:0] == 3'd5)
            && (m_tdata[5:3] == 3'd5))
        else $error("last entry not at row 5 column 5");

    // no error request in the middle of a matrix
    a_mid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !(m_tvalid && m_tuser[0]))
        else $error("error result inside a matrix");

endmodule

bind frame_element_stiffness_2d_core fes2d_checker u_chk (.*);
